// File: rtl/obstacle_avoid_drive_sequencer_core_macros.svh
`ifndef OBSTACLE_AVOID_DRIVE_SEQUENCER_CORE_MACROS_SVH
`define OBSTACLE_AVOID_DRIVE_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define OADS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define OADS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/oads_pkg.sv
package oads_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] dist_right_outer;
    logic [7:0] dist_right;
    logic [7:0] dist_centre;
    logic [7:0] dist_left;
    logic [7:0] dist_left_outer;
  } in_word_t;

  typedef struct packed {
    logic [3:0]        mode_code;
    logic signed [7:0] right_speed;
    logic signed [7:0] left_speed;
    logic              led_right;
    logic              led_blue;
    logic              led_white;
  } out_word_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [3:0] MODE_WAIT       = 4'd0;
  localparam logic [3:0] MODE_WAIT_HOLD  = 4'd1;
  localparam logic [3:0] MODE_FWD        = 4'd2;
  localparam logic [3:0] MODE_FWD_HOLD   = 4'd3;
  localparam logic [3:0] MODE_TL         = 4'd4;
  localparam logic [3:0] MODE_TL_HOLD    = 4'd5;
  localparam logic [3:0] MODE_TR         = 4'd6;
  localparam logic [3:0] MODE_TR_HOLD    = 4'd7;
  localparam logic [3:0] MODE_SL         = 4'd8;
  localparam logic [3:0] MODE_SL_HOLD    = 4'd9;
  localparam logic [3:0] MODE_SR         = 4'd10;
  localparam logic [3:0] MODE_SR_HOLD    = 4'd11;

  localparam logic [2:0] REG_WAIT_TICKS = 3'd0;
  localparam logic [2:0] REG_OUTER_THR  = 3'd1;
  localparam logic [2:0] REG_INNER_THR  = 3'd2;
  localparam logic [2:0] REG_CENTRE_THR = 3'd3;
  localparam logic [2:0] REG_LED_THR    = 3'd4;
  localparam logic [2:0] REG_FWD_SPEED  = 3'd5;
  localparam logic [2:0] REG_SPIN_SPEED = 3'd6;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

endpackage

// File: rtl/obstacle_avoid_drive_sequencer_core.sv
// Each accepted input word yields a registered result word in the next cycle.
// Throughput: one word per cycle; the state update and the result register
// load happen at the same edge; a result the sink holds back blocks input.
// Reset (rst, synchronous): mode, counter, setpoints and LED flags clear,
// registers return to their defaults, no result is pending.
`include "obstacle_avoid_drive_sequencer_core_macros.svh"

module obstacle_avoid_drive_sequencer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  oads_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oads_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import oads_pkg::*;

  logic [15:0] wait_ticks;
  logic [7:0]  outer_threshold;
  logic [7:0]  inner_threshold;
  logic [7:0]  centre_threshold;
  logic [7:0]  led_threshold;
  logic [6:0]  forward_speed;
  logic [6:0]  spin_speed;

  logic [3:0]  mode, mode_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  right_setpoint, right_setpoint_next;
  logic [7:0]  left_setpoint, left_setpoint_next;
  logic [2:0]  led_flags, led_flags_next;

  logic       accept;
  logic [3:0] choice;
  logic [7:0] fwd8, spin8, spin8_neg;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign fwd8      = {1'b0, forward_speed};
  assign spin8     = {1'b0, spin_speed};
  assign spin8_neg = 8'(~spin8 + 8'd1);

  always_comb begin
    if (in_data.dist_right_outer < outer_threshold && in_data.dist_right < inner_threshold &&
        in_data.dist_centre > centre_threshold && in_data.dist_left > inner_threshold &&
        in_data.dist_left_outer > outer_threshold) begin
      choice = MODE_TL;
    end else if (in_data.dist_right_outer > outer_threshold &&
                 in_data.dist_right > inner_threshold &&
                 in_data.dist_centre > centre_threshold &&
                 in_data.dist_left < inner_threshold &&
                 in_data.dist_left_outer < outer_threshold) begin
      choice = MODE_TR;
    end else if (in_data.dist_centre < centre_threshold) begin
      choice = MODE_SL;
    end else begin
      choice = MODE_FWD;
    end
  end

  always_comb begin
    mode_next           = mode;
    tick_count_next     = tick_count;
    right_setpoint_next = right_setpoint;
    left_setpoint_next  = left_setpoint;
    led_flags_next      = led_flags;
    if (in_data.kind == KIND_TICK) begin
      if (tick_count != TICK_MAX) begin
        tick_count_next = tick_count + 16'd1;
      end
    end else begin
      led_flags_next = {in_data.dist_left_outer < led_threshold,
                        in_data.dist_centre < led_threshold,
                        in_data.dist_right < led_threshold};
      case (mode)
        MODE_WAIT: begin
          // counter just cleared, so the exit test cannot pass here
          tick_count_next     = 16'd0;
          right_setpoint_next = 8'd0;
          left_setpoint_next  = 8'd0;
          mode_next           = MODE_WAIT_HOLD;
        end
        MODE_WAIT_HOLD: begin
          if (tick_count > wait_ticks) begin
            mode_next = MODE_FWD;
          end
        end
        MODE_FWD: begin
          right_setpoint_next = fwd8;
          left_setpoint_next  = fwd8;
          mode_next           = MODE_FWD_HOLD;
        end
        MODE_TL: begin
          right_setpoint_next = fwd8;
          left_setpoint_next  = 8'd0;
          mode_next           = MODE_TL_HOLD;
        end
        MODE_TR: begin
          right_setpoint_next = 8'd0;
          left_setpoint_next  = fwd8;
          mode_next           = MODE_TR_HOLD;
        end
        MODE_SL: begin
          right_setpoint_next = spin8;
          left_setpoint_next  = spin8_neg;
          mode_next           = MODE_SL_HOLD;
        end
        MODE_SR: begin
          right_setpoint_next = spin8_neg;
          left_setpoint_next  = spin8;
          mode_next           = MODE_SR_HOLD;
        end
        MODE_FWD_HOLD, MODE_TL_HOLD, MODE_TR_HOLD, MODE_SL_HOLD, MODE_SR_HOLD: begin
          if (choice != {mode[3:1], 1'b0}) begin
            mode_next = choice;
          end
        end
        default: begin
          mode_next = MODE_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks       <= 16'd1000;
      outer_threshold  <= 8'd30;
      inner_threshold  <= 8'd25;
      centre_threshold <= 8'd20;
      led_threshold    <= 8'd30;
      forward_speed    <= 7'd24;
      spin_speed       <= 7'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAIT_TICKS: wait_ticks       <= cfg_data;
        REG_OUTER_THR:  outer_threshold  <= cfg_data[7:0];
        REG_INNER_THR:  inner_threshold  <= cfg_data[7:0];
        REG_CENTRE_THR: centre_threshold <= cfg_data[7:0];
        REG_LED_THR:    led_threshold    <= cfg_data[7:0];
        REG_FWD_SPEED:  forward_speed    <= cfg_data[6:0];
        REG_SPIN_SPEED: spin_speed       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_WAIT;
      tick_count     <= 16'd0;
      right_setpoint <= 8'd0;
      left_setpoint  <= 8'd0;
      led_flags      <= 3'd0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        mode           <= mode_next;
        tick_count     <= tick_count_next;
        right_setpoint <= right_setpoint_next;
        left_setpoint  <= left_setpoint_next;
        led_flags      <= led_flags_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.mode_code   <= mode_next;
      out_data.right_speed <= right_setpoint_next;
      out_data.left_speed  <= left_setpoint_next;
      out_data.led_right   <= led_flags_next[0];
      out_data.led_blue    <= led_flags_next[1];
      out_data.led_white   <= led_flags_next[2];
    end
  end

  `OADS_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted word gave no result")
  `OADS_ASSERT_NOW(a_mode_known, 1'b1, mode <= MODE_SR_HOLD, "mode left the known codes")
  `OADS_ASSERT_NOW(a_out_mode_matches, out_valid, out_data.mode_code == mode, "result mode stale")
  `OADS_ASSERT_NEXT(a_tick_keeps_mode, accept && in_data.kind == KIND_TICK, $stable(mode), "tick moved mode")
  `OADS_ASSERT_NEXT(a_wait_entry, accept && in_data.kind == KIND_STEP && mode == MODE_WAIT, tick_count == 16'd0 && mode == MODE_WAIT_HOLD, "wait entry wrong")

endmodule
